// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic       finish;
		logic [7:0] data_byte;
	} req_t;

	localparam word_t START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t rotr(word_t x, int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- hw/rtl/sha256_front.sv -----
module sha256_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha256_pkg::req_t    in_req,
	output logic                q_valid,
	input  logic                q_ready,
	output sha256_pkg::req_t    q_req
);
	import sha256_pkg::*;

	// two-entry queue decouples intake from the compression engine
	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- hw/rtl/sha256_back.sv -----
module sha256_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  sha256_pkg::req_t    q_req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_word,
	output logic [2:0]          out_index,
	output logic                out_last
);
	import sha256_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RUN   = 6'b000010,
		ST_ADD   = 6'b000100,
		ST_CLEAR = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_PADB  = 6'b100000
	} state_t;

	state_t     state_q;
	word_t      hash_q [8];
	word_t      blk_q  [16];
	word_t      var_q  [8];
	logic [63:0] bits_q;
	logic [5:0] round_q;
	logic [2:0] emit_q;
	logic       fin_q;    // current compression belongs to a finish
	logic       second_q; // a length-only block follows

	logic [5:0] pos;
	logic [3:0] wi;
	logic [4:0] sh;
	word_t      put_word;
	logic [7:0] byte_in;

	assign pos     = bits_q[8:3];
	assign wi      = pos[5:2];
	assign sh      = 5'd24 - {pos[1:0], 3'b000};
	assign byte_in = q_req.finish ? PAD_BYTE : q_req.data_byte;
	assign put_word = (pos[1:0] == 2'd0) ? (word_t'(byte_in) << sh)
		: (blk_q[wi] | (word_t'(byte_in) << sh));

	// one round: schedule word update and compression round
	word_t x1, x14, s0, s1, wnew, w, t1, t2;
	always_comb begin
		x1   = blk_q[4'(round_q + 6'd1)];
		x14  = blk_q[4'(round_q + 6'd14)];
		s0   = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
		s1   = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
		wnew = blk_q[round_q[3:0]] + s1 + blk_q[4'(round_q + 6'd9)] + s0;
		w    = (round_q >= 6'd16) ? wnew : blk_q[round_q[3:0]];
		t1   = var_q[7] + (rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25))
			+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) + ROUND_K[round_q] + w;
		t2   = (rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22))
			+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
	end

	assign q_ready   = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_word  = hash_q[emit_q];
	assign out_index = emit_q;
	assign out_last  = (emit_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bits_q   <= '0;
			round_q  <= '0;
			emit_q   <= '0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= START_HASH[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						blk_q[wi] <= put_word;
						for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
						round_q <= '0;
						if (!q_req.finish) begin
							bits_q <= bits_q + 64'd8;
							fin_q  <= 1'b0;
							if (pos == 6'd63) state_q <= ST_RUN;
						end else begin
							fin_q    <= 1'b1;
							second_q <= (pos >= 6'd56);
							// zero words after the pad byte; the length goes in the last two words when it fits
							for (int i = 0; i < 14; i++) begin
								if (4'(i) > wi) blk_q[i] <= '0;
							end
							if (pos < 6'd56) begin
								blk_q[14] <= bits_q[63:32];
								blk_q[15] <= bits_q[31:0];
							end else if (wi == 4'd14) begin
								blk_q[15] <= '0;
							end
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (round_q >= 6'd16) blk_q[round_q[3:0]] <= wnew;
					for (int i = 0; i < 8; i++) begin
						if (i != 0 && i != 4) var_q[i] <= var_q[i-1];
					end
					var_q[4] <= var_q[3] + t1;
					var_q[0] <= t1 + t2;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
					if (!fin_q) state_q <= ST_IDLE;
					else if (second_q) state_q <= ST_PADB;
					else begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_PADB: begin
					// length-only block after a pad that overflowed
					for (int i = 0; i < 14; i++) blk_q[i] <= '0;
					blk_q[14] <= bits_q[63:32];
					blk_q[15] <= bits_q[31:0];
					for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
					round_q  <= '0;
					second_q <= 1'b0;
					state_q  <= ST_RUN;
				end
				ST_EMIT: begin
					if (out_ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= START_HASH[i];
					bits_q  <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/sha256_message_hasher.sv -----
// channel | dir | tdata                          | tuser     | tlast
// s_axis  | in  | [7:0] data_byte                | command   | -
// m_axis  | out | [31:0] digest_word, [34:32] idx| -         | last_word
// Every 64th absorbed byte starts the one-round-per-cycle compression loop
// (ST_RUN, then ST_ADD). A finish runs one or two compressions and then
// shows eight digest words, one per accepted cycle, then restores the
// initial hash in ST_CLEAR. A two-entry request queue keeps intake open
// while the engine works; reset returns the hash, bit count and queue to start.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
	output logic        m_axis_tlast
);
	import sha256_pkg::*;

	req_t        in_req, q_req;
	logic        q_valid, q_ready;
	logic [31:0] word;
	logic [2:0]  idx;

	assign in_req.finish    = s_axis_tuser;
	assign in_req.data_byte = s_axis_tdata;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	sha256_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(word), .out_index(idx), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, idx, word};
endmodule
